### sv/positional_array_list_assert.svh
// Assertion macros used by the positional array list sequencer.
`ifndef POSITIONAL_ARRAY_LIST_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PAL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_array_list: check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PAL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_array_list: check failed");

`endif

### sv/pal_pkg.sv
// Shared types and constants of the positional array list.
package pal_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CAP_W    = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [KIND_W-1:0] {
        OP_INSERT = 2'd0,
        OP_GET    = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage

### sv/pal_if.sv
// Request and response channel interfaces of the positional array list.
interface pal_req_if import pal_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink (input valid, input kind, input position, input value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output data, output count, input ready);
    modport sink (input valid, input status, input data, input count, output ready);
endinterface

### sv/pal_mem.sv
// Entry store: one write port and one read port with registered read data.
module pal_mem import pal_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] store_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/pal_ctrl.sv
// Operation sequencer: decodes requests and moves entries through the store.
`include "positional_array_list_assert.svh"

module pal_ctrl import pal_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int LW    = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    pal_req_if.sink           req,
    input  logic [CAP_W-1:0]  capacity,
    output logic              res_valid,
    output result_t           res,
    input  logic              res_ready,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output logic [DATA_W-1:0] mem_wr_data,
    output logic              mem_rd_en,
    output logic [AW-1:0]     mem_rd_addr,
    input  logic [DATA_W-1:0] mem_rd_data
);

    localparam int CMPW = (LW > CAP_W) ? LW : CAP_W;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_PUT   = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [LW-1:0]       len_reg, len_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                rd_cap_reg, rd_cap_next;
    logic [AW-1:0]       rd_dst_reg, rd_dst_next;
    logic                first_reg, first_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       end_reg, end_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;

    logic            accept;
    logic [CMPW-1:0] len_c;
    logic [CMPW-1:0] pos_c;
    logic [CMPW-1:0] cap_c;
    logic [CMPW-1:0] ucap_c;
    logic [CMPW-1:0] ins_pos_c;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign len_c     = CMPW'(len_reg);
    assign pos_c     = CMPW'(req.position);
    assign cap_c     = CMPW'(capacity);
    assign ucap_c    = (cap_c > DEPTH_C) ? DEPTH_C : cap_c;
    assign ins_pos_c = (pos_c > len_c) ? len_c : pos_c;

    // A read issued last cycle either lands in the result (first read of a get or delete)
    // or is written back one place up or down. The put of an inserted word has the port
    // to itself, since the drain state empties the read pipe first.
    assign mem_wr_en   = (rd_pend_reg && !rd_cap_reg) || (state_reg == S_PUT);
    assign mem_wr_addr = (state_reg == S_PUT) ? pos_reg : rd_dst_reg;
    assign mem_wr_data = (state_reg == S_PUT) ? val_reg : mem_rd_data;
    assign mem_rd_en   = (state_reg == S_SCAN);
    assign mem_rd_addr = ptr_reg;

    assign res_valid  = (state_reg == S_RESP);
    assign res.status = status_reg;
    assign res.data   = data_reg;
    assign res.count  = COUNT_W'(len_reg);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        rd_pend_next = 1'b0;
        rd_cap_next = rd_cap_reg;
        rd_dst_next = rd_dst_reg;
        first_next  = first_reg;
        kind_next   = kind_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        status_next = status_reg;
        data_next   = data_reg;

        if (rd_pend_reg && rd_cap_reg)
        begin
            data_next = mem_rd_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = req.kind;
                    val_next    = req.value;
                    status_next = ST_OK;
                    data_next   = '0;
                    first_next  = 1'b1;
                    case (req.kind)
                        OP_INSERT:
                        begin
                            if (len_c >= ucap_c)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                pos_next = AW'(ins_pos_c);
                                if (ins_pos_c == len_c)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    // Shift from the last entry down to the insert point.
                                    ptr_next   = AW'(len_c - CMPW'(1));
                                    end_next   = AW'(ins_pos_c);
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        OP_GET, OP_DELETE:
                        begin
                            if (pos_c >= len_c)
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = AW'(pos_c);
                                end_next   = (req.kind == OP_GET) ? AW'(pos_c)
                                                                  : AW'(len_c - CMPW'(1));
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            len_next   = '0;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_pend_next = 1'b1;
                rd_cap_next  = first_reg && (kind_reg != OP_INSERT);
                rd_dst_next  = (kind_reg == OP_INSERT) ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                first_next   = 1'b0;
                if (ptr_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else if (kind_reg == OP_INSERT)
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (kind_reg == OP_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    if (kind_reg == OP_DELETE)
                    begin
                        len_next = len_reg - LW'(1);
                    end
                    state_next = S_RESP;
                end
            end
            S_PUT:
            begin
                len_next   = len_reg + LW'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_cap_reg <= rd_cap_next;
        rd_dst_reg <= rd_dst_next;
        first_reg  <= first_next;
        kind_reg   <= kind_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        status_reg <= status_next;
        data_reg   <= data_next;
    end

    `PAL_ASSERT_IMP(a_len_bound, 1'b1, CMPW'(len_reg) <= DEPTH_C)
    `PAL_ASSERT_IMP(a_no_rw_same_entry, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr)
    `PAL_ASSERT_NXT(a_clear_empties, accept && (req.kind == OP_CLEAR), len_reg == '0)
    `PAL_ASSERT_IMP(a_no_write_idle, mem_wr_en, state_reg != S_IDLE)
    `PAL_ASSERT_NXT(a_result_holds, res_valid && !res_ready, res_valid)

endmodule

### sv/positional_array_list.sv
// Positional array list top level: sequencer, entry store with one read and one write port.
// A get reads entry p; an insert at position p with length n shifts the entries from n - 1
// down to p one place up and then puts the new word (an append only puts it); a delete reads
// entry p and shifts the rest one place down. Clear, a full insert and an out-of-range get or
// delete answer without the store. The shift loop moves one entry per cycle through the store.
// Reset (rst_n low, asynchronous) empties the list and sets capacity to 64; entries persist.
module positional_array_list import pal_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    pal_req_if.sink          req,
    pal_rsp_if.source        rsp,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] capacity_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;

    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    // The output register frees the sequencer as soon as a result is parked.
    assign res_ready      = !out_valid_reg || rsp.ready;
    assign out_valid_next = (res_valid && res_ready) || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_res_reg.status;
    assign rsp.data   = out_res_reg.data;
    assign rsp.count  = out_res_reg.count;

    pal_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .LW    (LW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .capacity    (capacity_reg),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    pal_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

### test/positional_array_list_tb.sv
// Self-checking testbench of the positional array list: random and directed list operations.
module positional_array_list_tb;
    import pal_pkg::*;

    localparam int DEPTH      = 64;
    localparam int N_PHASES   = 10;
    localparam int PHASE_OPS  = 123;
    localparam int LAT_SLACK  = 8;
    localparam int END_SLACK  = 80;

    typedef struct {
        op_t               kind;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } list_req_t;

    localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] =
        '{7'd1, 7'd0, 7'd127, 7'd64, 7'd17, 7'd100, 7'd2, 7'd64, 7'd33, 7'd5};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    pal_req_if req_ch ();
    pal_rsp_if rsp_ch ();

    positional_array_list #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // Shadow copy of the list as the block should hold it.
    logic [DATA_W-1:0]  shadow_words [DEPTH];
    logic [COUNT_W-1:0] shadow_len;
    logic [CAP_W-1:0]   shadow_cap;

    list_req_t   queued_requests [$];
    result_t     predicted_replies [$];

    int unsigned send_idle_pct  = 19;
    int unsigned recv_stall_pct = 64;

    int op_counts [4];
    int full_answers;
    int range_answers;
    int longest_list;
    int replies_seen;
    int mismatches;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic result_t apply_list_op(input list_req_t op);
        result_t     r;
        int unsigned eff_cap;
        int unsigned p;
        int unsigned i;
        r.status = ST_OK;
        r.data   = '0;
        eff_cap  = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        p        = op.position;
        case (op.kind)
            OP_INSERT:
            begin
                if (shadow_len >= eff_cap)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    // Positions past the end append.
                    if (p > shadow_len)
                        p = shadow_len;
                    for (i = shadow_len; i > p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = op.value;
                    shadow_len = shadow_len + 1'b1;
                end
            end
            OP_GET:
            begin
                if (p >= shadow_len)
                    r.status = ST_RANGE;
                else
                    r.data = shadow_words[p];
            end
            OP_DELETE:
            begin
                if (p >= shadow_len)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    r.data = shadow_words[p];
                    for (i = p + 1; i < shadow_len; i++)
                        shadow_words[i-1] = shadow_words[i];
                    shadow_len = shadow_len - 1'b1;
                end
            end
            default:
            begin
                shadow_len = '0;
            end
        endcase
        r.count = shadow_len;
        return r;
    endfunction

    task automatic push_op(input op_t kind, input int position, input logic [DATA_W-1:0] value);
        list_req_t op;
        op.kind     = kind;
        op.position = POS_W'(position);
        op.value    = value;
        queued_requests.push_back(op);
    endtask

    // Random operations steered toward a fill level that changes every few dozen items,
    // so the list spends time both nearly empty and at its capacity.
    task automatic queue_random_ops(input int n);
        list_req_t   op;
        int unsigned gen_len;
        int unsigned eff_cap;
        int unsigned fill_target;
        int unsigned roll;
        int unsigned span;
        int          i;
        gen_len     = shadow_len;
        eff_cap     = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        fill_target = 0;
        for (i = 0; i < n; i++)
        begin
            if (i % 48 == 0)
            begin
                fill_target = ($urandom_range(0, 1) == 1) ? DEPTH : $urandom_range(0, DEPTH);
                if (fill_target > eff_cap)
                    fill_target = eff_cap;
            end
            roll     = $urandom_range(0, 99);
            span     = (gen_len > DEPTH - 1) ? DEPTH - 1 : gen_len;
            op.value = $urandom;
            if ($urandom_range(0, 99) < 20)
                op.position = POS_W'($urandom_range(0, DEPTH - 1));
            else
                op.position = POS_W'($urandom_range(0, span));
            if (gen_len >= fill_target && roll < 2)
                op.kind = OP_CLEAR;
            else if (roll < ((gen_len < fill_target) ? 85 : 35))
                op.kind = OP_INSERT;
            else if (roll[0])
                op.kind = OP_GET;
            else
                op.kind = OP_DELETE;
            case (op.kind)
                OP_INSERT: if (gen_len < eff_cap) gen_len++;
                OP_DELETE: if (op.position < gen_len) gen_len--;
                OP_CLEAR:  gen_len = 0;
                default:   ;
            endcase
            queued_requests.push_back(op);
        end
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shadow_cap  = cap;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (queued_requests.size() != 0 || req_ch.valid || predicted_replies.size() != 0)
            @(negedge clk);
    endtask

    // Request driver: predicts each transfer as it is accepted.
    always @(posedge clk)
    begin
        list_req_t op;
        result_t   r;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                op.kind     = op_t'(req_ch.kind);
                op.position = req_ch.position;
                op.value    = req_ch.value;
                r = apply_list_op(op);
                predicted_replies.push_back(r);
                op_counts[op.kind]++;
                if (r.status == ST_FULL)
                    full_answers++;
                if (r.status == ST_RANGE)
                    range_answers++;
                if (r.count > longest_list)
                    longest_list = r.count;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    op = queued_requests.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.kind     <= op.kind;
                    req_ch.position <= op.position;
                    req_ch.value    <= op.value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor with random back-pressure.
    always @(posedge clk)
    begin
        result_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            replies_seen++;
            if (predicted_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reply: status %0d data %h count %0d",
                             rsp_ch.status, rsp_ch.data, rsp_ch.count);
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.data !== want.data ||
                    rsp_ch.count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reply %0d: expected status %0d data %h count %0d, got status %0d data %h count %0d",
                                 replies_seen, want.status, want.data, want.count,
                                 rsp_ch.status, rsp_ch.data, rsp_ch.count);
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        int ph;
        logic [CAP_W-1:0] cap;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_ch.valid    = 1'b0;
        req_ch.kind     = OP_INSERT;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        shadow_len      = '0;
        shadow_cap      = CAP_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty list, appends at both ends, mid inserts, reads and removals at the edges.
        push_op(OP_GET,    0,  32'h0);
        push_op(OP_DELETE, 0,  32'h0);
        push_op(OP_INSERT, 63, 32'h0000_0000);
        push_op(OP_INSERT, 0,  32'hFFFF_FFFF);
        push_op(OP_INSERT, 1,  32'hA5A5_A5A5);
        push_op(OP_INSERT, 63, 32'h5A5A_5A5A);
        push_op(OP_INSERT, 2,  32'h0000_0001);
        push_op(OP_GET,    0,  32'h0);
        push_op(OP_GET,    4,  32'h0);
        push_op(OP_GET,    5,  32'h0);
        push_op(OP_GET,    63, 32'h0);
        push_op(OP_DELETE, 63, 32'h0);
        push_op(OP_DELETE, 4,  32'h0);
        push_op(OP_DELETE, 0,  32'h0);
        push_op(OP_DELETE, 1,  32'h0);
        push_op(OP_GET,    0,  32'h0);
        push_op(OP_GET,    1,  32'h0);
        push_op(OP_CLEAR,  0,  32'h0);
        push_op(OP_GET,    0,  32'h0);
        push_op(OP_DELETE, 0,  32'h0);
        push_op(OP_INSERT, 0,  32'h8000_0000);
        push_op(OP_CLEAR,  5,  32'h1234_5678);
        wait_drained();

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            // All replies are in; give the shift loop time to settle before reconfiguring.
            repeat (LAT_SLACK) @(posedge clk);
            cap = (ph == N_PHASES - 1) ? CAP_W'($urandom_range(1, DEPTH)) : PHASE_CAPS[ph];
            write_capacity(cap);
            @(negedge clk);
            if (ph == 3)
            begin
                send_idle_pct  = 64;
                recv_stall_pct = 19;
            end
            else if (ph == 7)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            queue_random_ops(PHASE_OPS);
            wait_drained();
        end

        repeat (END_SLACK) @(posedge clk);
        $display("Ran %0d list operations (%0d insert, %0d get, %0d delete, %0d clear) under %0d capacity settings.",
                 op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3],
                 op_counts[0], op_counts[1], op_counts[2], op_counts[3], N_PHASES + 1);
        $display("Saw %0d full and %0d out-of-range answers, longest list %0d, %0d replies checked.",
                 full_answers, range_answers, longest_list, replies_seen);
        if (mismatches == 0)
            $display("PASS positional_array_list");
        else
            $display("FAIL positional_array_list");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL positional_array_list");
        $finish;
    end

endmodule
